### rtl/core/osxc_pkg.sv
// ----------------------------------------------------------------------------
// osxc_pkg: shared types and constants for the one-sided cross-correlator
// Store depth, lag limits, datapath widths, register indexes and FSM states.
// ----------------------------------------------------------------------------
package osxc_pkg;

    localparam int FRAME_DEPTH = 1024;
    localparam int MAX_LAGS    = 64;

    localparam int ADDR_W  = $clog2(FRAME_DEPTH);
    localparam int CNT_W   = $clog2(FRAME_DEPTH + 1);
    localparam int LAG_W   = 6;
    localparam int LCNT_W  = 7;
    localparam int SAMP_W  = 16;
    localparam int PROD_W  = 2 * SAMP_W;
    localparam int ACC_W   = PROD_W + CNT_W - 1;
    localparam int DIV_W   = ACC_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int MEAN_W  = 32;
    localparam int SCALE_W = 32;
    localparam int VAL_W   = 40;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [LCNT_W-1:0]  LAG_COUNT_RST  = 7'd51;
    localparam logic [SCALE_W-1:0] NORM_SCALE_RST = 32'd3054199;

    localparam logic [CFG_IDX_W-1:0] REG_LAG_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE = 8'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SAMP_W-1:0] ipsi;
        logic [SAMP_W-1:0] contra;
    } osxc_wr_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_LAG,
        ST_MAC,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } osxc_state_t;

endpackage

### rtl/core/osxc_ifs.sv
// ----------------------------------------------------------------------------
// osxc interfaces: sample, result and configuration channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface osxc_in_if;
    import osxc_pkg::*;
    logic              valid;
    logic              ready;
    logic [SAMP_W-1:0] ipsi_sample;
    logic [SAMP_W-1:0] contra_sample;
    logic              last_sample;
    modport source (output valid, ipsi_sample, contra_sample, last_sample, input ready);
    modport sink   (input valid, ipsi_sample, contra_sample, last_sample, output ready);
endinterface

interface osxc_out_if;
    import osxc_pkg::*;
    logic             valid;
    logic             ready;
    logic [LAG_W-1:0] lag_index;
    logic [VAL_W-1:0] correlation_value;
    logic             last_lag;
    logic             no_overlap;
    logic             frame_overflow;
    modport source (output valid, lag_index, correlation_value, last_lag, no_overlap,
                    frame_overflow, input ready);
    modport sink   (input valid, lag_index, correlation_value, last_lag, no_overlap,
                    frame_overflow, output ready);
endinterface

interface osxc_cfg_if;
    import osxc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/one_sided_cross_correlator_top.sv
// ----------------------------------------------------------------------------
// one_sided_cross_correlator_top: one-sided cross-correlation of a frame
// Stores paired samples, then emits one normalized mean product per lag.
//
//   channel   role   payload
//   sample    sink   ipsi_sample, contra_sample, last_sample
//   result    source lag_index, correlation_value, last_lag, no_overlap,
//                    frame_overflow
//   cfg       sink   index, data (0: lag_count, 1: norm_scale)
//
// Non-final samples are accepted back to back. After the final one, each lag
// sums n - k products over the sample stores, divides the rounded magnitude
// by n - k in the divider and scales it; a lag with no overlap yields zero.
// The sample channel stays closed from the final sample to the last lag.
// A stalled result holds in the output register; work on the next lag goes on.
// Reset clears the sample count and overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module one_sided_cross_correlator_top (
    input  logic clk,
    input  logic rst_n,
    osxc_in_if.sink    sample,
    osxc_out_if.source result,
    osxc_cfg_if.sink   cfg
);
    import osxc_pkg::*;

    osxc_state_t         state_reg, state_next;
    logic [LCNT_W-1:0]   lag_count_reg;
    logic [SCALE_W-1:0]  norm_scale_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [LCNT_W-1:0]   lags_reg, lags_next;
    logic                fovf_reg, fovf_next;
    logic [LAG_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic                rd_vld_reg, rd_vld_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                nov_reg, nov_next;
    logic [MEAN_W-1:0]   mean_reg, mean_next;
    logic [2*MEAN_W-1:0] prod_reg, prod_next;

    logic                out_vld_reg, out_vld_next;
    logic [LAG_W-1:0]    out_lag_reg, out_lag_next;
    logic [VAL_W-1:0]    out_val_reg, out_val_next;
    logic                out_last_reg, out_last_next;
    logic                out_nov_reg, out_nov_next;
    logic                out_ovf_reg, out_ovf_next;

    logic                we;
    osxc_wr_t            wr;
    logic [ADDR_W-1:0]   ipsi_addr, contra_addr;
    logic [SAMP_W-1:0]   ipsi_data, contra_data;
    logic                div_start, div_done;
    logic [DIV_W-1:0]    div_dividend, div_quot;
    logic [ACC_W-1:0]    mag;
    logic signed [PROD_W-1:0] mac_prod;
    logic [MEAN_W:0]     scaled;
    logic [VAL_W-1:0]    lag_val;
    logic [LCNT_W-1:0]   lags_clamped;
    logic [CNT_W-1:0]    count_inc;
    logic                in_acc;
    logic                is_last;

    osxc_ram u_ram (
        .clk         (clk),
        .we          (we),
        .wr          (wr),
        .ipsi_addr   (ipsi_addr),
        .contra_addr (contra_addr),
        .ipsi_data   (ipsi_data),
        .contra_data (contra_data)
    );

    osxc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign cfg.ready    = 1'b1;
    assign sample.ready = (state_reg == ST_LOAD);
    assign in_acc       = sample.valid && sample.ready;

    assign wr.addr   = count_reg[ADDR_W-1:0];
    assign wr.ipsi   = sample.ipsi_sample;
    assign wr.contra = sample.contra_sample;
    assign we        = in_acc && (count_reg != CNT_W'(FRAME_DEPTH));
    assign count_inc = count_reg + 1'b1;

    assign ipsi_addr   = i_reg[ADDR_W-1:0];
    assign contra_addr = ADDR_W'(i_reg + CNT_W'(k_reg));

    assign mac_prod = $signed(contra_data) * $signed(ipsi_data);
    assign mag      = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_dividend = DIV_W'(mag + ACC_W'(len_reg >> 1));

    assign scaled  = (MEAN_W+1)'((prod_reg + 64'h8000_0000) >> MEAN_W);
    assign lag_val = nov_reg ? '0
                   : (neg_reg ? VAL_W'(-$signed({1'b0, scaled})) : VAL_W'(scaled));
    assign is_last = (LCNT_W'(k_reg) + 1'b1) == lags_reg;

    always_comb
    begin
        if (lag_count_reg == '0)
            lags_clamped = LCNT_W'(1);
        else if (lag_count_reg > LCNT_W'(MAX_LAGS))
            lags_clamped = LCNT_W'(MAX_LAGS);
        else
            lags_clamped = lag_count_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        lags_next    = lags_reg;
        fovf_next    = fovf_reg;
        k_next       = k_reg;
        len_next     = len_reg;
        i_next       = i_reg;
        rd_vld_next  = 1'b0;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        nov_next     = nov_reg;
        mean_next    = mean_reg;
        prod_next    = prod_reg;
        div_start    = 1'b0;
        out_vld_next  = out_vld_reg && !result.ready;
        out_lag_next  = out_lag_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        out_nov_next  = out_nov_reg;
        out_ovf_next  = out_ovf_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (we)
                        count_next = count_inc;
                    else
                        ovf_next = 1'b1;
                    if (sample.last_sample)
                    begin
                        n_next     = we ? count_inc : count_reg;
                        fovf_next  = ovf_reg || !we;
                        lags_next  = lags_clamped;
                        k_next     = '0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LAG;
                    end
                end
            end
            ST_LAG:
            begin
                len_next = n_reg - CNT_W'(k_reg);
                i_next   = '0;
                acc_next = '0;
                if (CNT_W'(k_reg) >= n_reg)
                begin
                    nov_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    nov_next   = 1'b0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                // issue one read pair per cycle, add the product in the next cycle
                if (i_reg != len_reg)
                begin
                    i_next      = i_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                    acc_next = acc_reg + ACC_W'(mac_prod);
                if (i_reg == len_reg && !rd_vld_reg)
                begin
                    neg_next   = acc_reg[ACC_W-1];
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_quot > DIV_W'(64'h8000_0000))
                        mean_next = 32'h8000_0000;
                    else
                        mean_next = div_quot[MEAN_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = mean_reg * norm_scale_reg;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait for a free output slot
                if (!out_vld_reg || result.ready)
                begin
                    out_vld_next  = 1'b1;
                    out_lag_next  = k_reg;
                    out_val_next  = lag_val;
                    out_last_next = is_last;
                    out_nov_next  = nov_reg;
                    out_ovf_next  = fovf_reg;
                    k_next        = k_reg + 1'b1;
                    state_next    = is_last ? ST_LOAD : ST_LAG;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            lag_count_reg  <= LAG_COUNT_RST;
            norm_scale_reg <= NORM_SCALE_RST;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            rd_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_LAG_COUNT)
                    lag_count_reg <= cfg.data[LCNT_W-1:0];
                else if (cfg.index == REG_NORM_SCALE)
                    norm_scale_reg <= cfg.data[SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        lags_reg     <= lags_next;
        fovf_reg     <= fovf_next;
        k_reg        <= k_next;
        len_reg      <= len_next;
        i_reg        <= i_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        nov_reg      <= nov_next;
        mean_reg     <= mean_next;
        prod_reg     <= prod_next;
        out_lag_reg  <= out_lag_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_nov_reg  <= out_nov_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign result.valid             = out_vld_reg;
    assign result.lag_index         = out_lag_reg;
    assign result.correlation_value = out_val_reg;
    assign result.last_lag          = out_last_reg;
    assign result.no_overlap        = out_nov_reg;
    assign result.frame_overflow    = out_ovf_reg;

endmodule

### rtl/core/osxc_ram.sv
// ----------------------------------------------------------------------------
// osxc_ram: paired sample stores
// One write port for both stores, one registered read port per store.
// ----------------------------------------------------------------------------
module osxc_ram (
    input  logic                      clk,
    input  logic                      we,
    input  osxc_pkg::osxc_wr_t        wr,
    input  logic [osxc_pkg::ADDR_W-1:0] ipsi_addr,
    input  logic [osxc_pkg::ADDR_W-1:0] contra_addr,
    output logic [osxc_pkg::SAMP_W-1:0] ipsi_data,
    output logic [osxc_pkg::SAMP_W-1:0] contra_data
);
    import osxc_pkg::*;

    logic [SAMP_W-1:0] ipsi_mem   [FRAME_DEPTH];
    logic [SAMP_W-1:0] contra_mem [FRAME_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ipsi_mem[wr.addr]   <= wr.ipsi;
            contra_mem[wr.addr] <= wr.contra;
        end
        ipsi_data   <= ipsi_mem[ipsi_addr];
        contra_data <= contra_mem[contra_addr];
    end

endmodule

### rtl/core/osxc_div.sv
// ----------------------------------------------------------------------------
// osxc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, pulses done when finished.
// ----------------------------------------------------------------------------
module osxc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [osxc_pkg::DIV_W-1:0]  dividend,
    input  logic [osxc_pkg::CNT_W-1:0]  divisor,
    output logic                        done,
    output logic [osxc_pkg::DIV_W-1:0]  quotient
);
    import osxc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // trial stays below twice the divisor, so one subtract settles the bit
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
